### rtl/core/psis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the phase-to-sine shaper: table geometry, widths and the
// quarter-wave sine table, which is computed at elaboration. No dependencies.
package psis_pkg;

  // Table geometry (power of two, 64 .. 65536)
  localparam int unsigned TABLE_SIZE = 2048;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned HALF       = TABLE_SIZE / 2;
  localparam int unsigned QUARTER    = TABLE_SIZE / 4;
  localparam int unsigned QDEPTH     = QUARTER + 1;
  localparam int unsigned QADDR_W    = $clog2(QDEPTH);

  // Datapath widths
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned FR_W     = PHASE_W - IDX_W;  // interpolation fraction
  localparam int unsigned ROM_W    = 31;               // magnitude 0 .. 2^30
  localparam int unsigned ENT_W    = ROM_W + 1;        // signed table entry
  // Neighbor entries differ by less than 2*pi/64 * 2^30 < 2^27
  localparam int unsigned DIFF_W   = 29;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // Taylor term divisors (2k)*(2k+1) for k = 1 .. 8
  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic [ROM_W-1:0] rom_word_t;
  typedef rom_word_t quarter_rom_t [QDEPTH];

  // One table read: folded magnitude and the sign to apply
  typedef struct packed {
    logic      neg;
    rom_word_t mag;
  } rom_ent_t;

  // Taylor series through x^17, Q30, truncated at every step
  function automatic rom_word_t quarter_sine(longint unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned k;
    longint          sum;
    x    = (64'd2 * PI_Q30 * i + 64'(HALF)) >> IDX_W;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[3'(k - 64'd1)];
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    if (sum < 0) begin
      sum = 0;
    end
    return ROM_W'(sum);
  endfunction

  function automatic quarter_rom_t build_quarter_rom();
    quarter_rom_t rom;
    for (int unsigned k = 0; k < QUARTER; k++) begin
      rom[k] = quarter_sine(64'(k));
    end
    rom[QUARTER] = ROM_W'(ONE_Q30);
    return rom;
  endfunction

  localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

endpackage
`default_nettype wire

### rtl/core/psis_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Stream interfaces of the phase-to-sine shaper: phase items in, samples out.
// Depends on psis_pkg for field widths.
interface psis_in_if import psis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [PHASE_W-1:0]         phase;
  logic signed [SAMPLE_W-1:0] gain;
  logic signed [SAMPLE_W-1:0] offset;

  modport source (output valid, output phase, output gain, output offset, input ready);
  modport sink   (input valid, input phase, input gain, input offset, output ready);
endinterface

interface psis_out_if import psis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

### rtl/core/psis_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// Dual-read sine table: folds full-cycle indices onto the quarter-wave table
// and returns registered magnitude plus sign. Depends on psis_pkg.
module psis_sine_rom import psis_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [IDX_W:0] idx_a_i,
  input  wire logic [IDX_W:0] idx_b_i,
  output rom_ent_t            ent_a_o,
  output rom_ent_t            ent_b_o
);

  localparam logic [IDX_W:0] FULL_K    = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W:0] HALF_K    = (IDX_W + 1)'(HALF);
  localparam logic [IDX_W:0] QUARTER_K = (IDX_W + 1)'(QUARTER);

  typedef struct packed {
    logic               neg;
    logic [QADDR_W-1:0] addr;
  } rom_ref_t;

  // Second half is the negated mirror, second quarter mirrors the first
  function automatic rom_ref_t fold_index(logic [IDX_W:0] k);
    rom_ref_t       r;
    logic [IDX_W:0] m;
    if (k <= HALF_K) begin
      r.neg = 1'b0;
      m     = k;
    end else begin
      r.neg = 1'b1;
      m     = FULL_K - k;
    end
    if (m <= QUARTER_K) begin
      r.addr = QADDR_W'(m);
    end else begin
      r.addr = QADDR_W'(HALF_K - m);
    end
    return r;
  endfunction

  rom_ref_t ref_a, ref_b;
  rom_ent_t ent_a_q, ent_b_q;

  assign ref_a = fold_index(idx_a_i);
  assign ref_b = fold_index(idx_b_i);

  // Registered read of both ports
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_a_q.neg <= ref_a.neg;
      ent_a_q.mag <= QUARTER_ROM[ref_a.addr];
      ent_b_q.neg <= ref_b.neg;
      ent_b_q.mag <= QUARTER_ROM[ref_b.addr];
    end
  end

  assign ent_a_o = ent_a_q;
  assign ent_b_o = ent_b_q;

endmodule
`default_nettype wire

### rtl/core/phase_to_sine_interpolated_shaper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Phase-to-sine shaper: table lookup, linear interpolation, gain and offset.
// Depends on psis_pkg, psis_if (psis_in_if, psis_out_if) and psis_sine_rom.
//
//   port   direction  fields                         transfer
//   in_i   sink       phase[31:0] gain[23:0] offset  valid & ready
//   out_o  source     sample_out[23:0]               valid & ready
//
// One item per cycle sustained while out_o.ready holds; five register
// stages: table read, difference times fraction, interpolation add, gain
// multiply, offset add with rounding and saturation. Output valid is
// registered; an item passes v1_q, v2_q, v3_q, v4_q and out_vld_q in turn.
// The table needs no fill after reset; only valid bits are reset.
// Each stage moves when it is empty or the next one moves, so bubbles close
// up and a stalled output holds its sample while earlier stages still fill.
module phase_to_sine_interpolated_shaper_unit import psis_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psis_in_if.sink    in_i,
  psis_out_if.source out_o
);

  localparam int unsigned PROD_W = DIFF_W + FR_W + 1;
  localparam int unsigned MUL_W  = ENT_W + SAMPLE_W;
  localparam int unsigned ACC_W  = MUL_W + 1;
  localparam int unsigned R_W    = ACC_W - 30;

  localparam logic signed [PROD_W-1:0] PROD_HALF =
    {{(PROD_W - FR_W){1'b0}}, 1'b1, {(FR_W - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_HALF =
    {{(ACC_W - 30){1'b0}}, 1'b1, {29{1'b0}}};

  // Stage valid bits and enables
  logic v1_q, v2_q, v3_q, v4_q, out_vld_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !out_vld_q || out_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1;

  // Input: table index pair and fraction
  logic [IDX_W-1:0] idx;
  logic [IDX_W:0]   idx_a, idx_b;

  assign idx   = in_i.phase[PHASE_W-1 -: IDX_W];
  assign idx_a = {1'b0, idx};
  assign idx_b = idx_a + (IDX_W + 1)'(1);

  rom_ent_t ent_a, ent_b;

  psis_sine_rom u_rom (
    .clk_i   (clk_i),
    .en_i    (en1),
    .idx_a_i (idx_a),
    .idx_b_i (idx_b),
    .ent_a_o (ent_a),
    .ent_b_o (ent_b)
  );

  // Stage 1 payload beside the table read
  logic [FR_W-1:0]            fr1_q;
  logic signed [SAMPLE_W-1:0] gain1_q, off1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      fr1_q   <= in_i.phase[FR_W-1:0];
      gain1_q <= in_i.gain;
      off1_q  <= in_i.offset;
    end
  end

  // Signed entries, neighbor difference, product with fraction
  logic signed [ENT_W-1:0]  mag_a, mag_b, e0, e1;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;

  assign mag_a = $signed({1'b0, ent_a.mag});
  assign mag_b = $signed({1'b0, ent_b.mag});
  assign e0    = ent_a.neg ? -mag_a : mag_a;
  assign e1    = ent_b.neg ? -mag_b : mag_b;
  assign diff  = DIFF_W'(e1 - e0);
  assign prod  = PROD_W'(diff) * PROD_W'($signed({1'b0, fr1_q}));

  logic signed [ENT_W-1:0]    e0_2_q;
  logic signed [PROD_W-1:0]   prod2_q;
  logic signed [SAMPLE_W-1:0] gain2_q, off2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      e0_2_q  <= e0;
      prod2_q <= prod;
      gain2_q <= gain1_q;
      off2_q  <= off1_q;
    end
  end

  // Interpolated value: entry plus rounded step
  logic signed [PROD_W-1:0] rnd;
  logic signed [DIFF_W:0]   step;
  logic signed [ENT_W-1:0]  interp;

  assign rnd    = prod2_q + PROD_HALF;
  assign step   = $signed(rnd[PROD_W-1:FR_W]);
  assign interp = e0_2_q + ENT_W'(step);

  logic signed [ENT_W-1:0]    v3_val_q;
  logic signed [SAMPLE_W-1:0] gain3_q, off3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      v3_val_q <= interp;
      gain3_q  <= gain2_q;
      off3_q   <= off2_q;
    end
  end

  // Gain multiply
  logic signed [MUL_W-1:0]    mul4_q;
  logic signed [SAMPLE_W-1:0] off4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      mul4_q <= MUL_W'(v3_val_q) * MUL_W'(gain3_q);
      off4_q <= off3_q;
    end
  end

  // Offset, rounding to integer (30 fraction bits dropped), saturation
  logic signed [ACC_W-1:0]    acc;
  logic signed [R_W-1:0]      r;
  logic                       sat_hi, sat_lo;
  logic signed [SAMPLE_W-1:0] sample;

  assign acc    = ACC_W'(mul4_q) + (ACC_W'(off4_q) <<< 30) + ACC_HALF;
  assign r      = $signed(acc[ACC_W-1:30]);
  assign sat_hi = !r[R_W-1] && (r[R_W-2:SAMPLE_W-1] != '0);
  assign sat_lo = r[R_W-1] && (r[R_W-2:SAMPLE_W-1] != '1);

  always_comb begin
    priority if (sat_hi) begin
      sample = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else if (sat_lo) begin
      sample = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      sample = r[SAMPLE_W-1:0];
    end
  end

  logic signed [SAMPLE_W-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_data_q <= sample;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en1) v1_q      <= in_i.valid;
      if (en2) v2_q      <= v1_q;
      if (en3) v3_q      <= v2_q;
      if (en4) v4_q      <= v3_q;
      if (en5) out_vld_q <= v4_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_data_q;

`ifndef ASSERT_OFF
  // An input transfer always lands in the first stage
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v1_q)
    else $error("accepted item missing from stage 1");

  // A full pipeline with a stalled output must refuse input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready && v1_q && v2_q && v3_q && v4_q |-> !in_i.ready)
    else $error("input accepted into a full stalled pipeline");

  // The last stage hands its item to the output register when it moves
  a_last_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && en5 |=> out_vld_q)
    else $error("item lost between gain stage and output");
`endif

endmodule
`default_nettype wire
